### hw/rtl/crcfc_pkg.sv
`default_nettype none

package crcfc_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 512;

   localparam logic [7:0]  VERSION_RESET = 8'h01;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   // header is version, kind, sequence (2), length (2); CRC trailer is 2 bytes
   localparam int unsigned HDR_BYTES = 6;
   localparam int unsigned CRC_BYTES = 2;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_VERSION = 1'b0;

   typedef enum logic [2:0] {
      ERR_OK      = 3'd0,
      ERR_SHORT   = 3'd1,
      ERR_VERSION = 3'd2,
      ERR_LENGTH  = 3'd3,
      ERR_TRUNC   = 3'd4,
      ERR_CRC     = 3'd5
   } err_code_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } rsp_kind_type;

   // result payload, lowest field in the lowest bits, padded to 88 bits
   typedef struct packed {
      logic [3:0]   pad;
      logic [15:0]  computed_check;
      logic [15:0]  received_check;
      logic [15:0]  declared_length;
      logic [15:0]  sequence_res;
      logic [7:0]   msg_kind;
      err_code_type error_code;
      logic         frame_ok;
      logic [7:0]   payload_byte;
   } rsp_data_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/crc_frame_checker.sv
`default_nettype none

// Frame checker for a received buffer, one byte per transfer on req_ with the final
// byte marked by req_tlast. The buffer must hold a six-byte little-endian header
// (version, message kind, sequence, payload length), the payload and a little-endian
// CRC-16/CCITT-FALSE over header and payload. Payload bytes come out on rsp_ with
// rsp_tuser low as they arrive, unless the declared length exceeds MAX_PAYLOAD; the
// final byte yields one verdict transfer with rsp_tuser high carrying the error code,
// the header fields and both CRC values, and the checker then starts afresh. Bytes
// after the CRC are ignored. A byte is taken every cycle: the CRC update and all checks
// are combinational and land in a single result register, and req_tready drops only while
// that register holds a result that rsp_tready has not yet taken. expected_version
// (reset 1) lies at CSR byte address 0.
module crc_frame_checker #(
   parameter int unsigned MAX_PAYLOAD = crcfc_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  wire logic                               req_tlast,  // last_byte

   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] payload_byte, [8] frame_ok, [11:9] error_code, [19:12] msg_kind,
   // [35:20] sequence_res, [51:36] declared_length, [67:52] received_check,
   // [83:68] computed_check, [87:84] zero
   output      logic [87:0]                        rsp_tdata,
   output      logic                               rsp_tuser,  // result_kind

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [crcfc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [crcfc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [crcfc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                               csr_pready
);
   import crcfc_pkg::*;

   localparam int unsigned POS_SAT = (MAX_PAYLOAD + HDR_BYTES + CRC_BYTES > 1023) ?
                                     (MAX_PAYLOAD + HDR_BYTES + CRC_BYTES) : 1023;
   localparam int unsigned POS_W   = $clog2(POS_SAT + 1);
   localparam int unsigned CMP_W   = ((POS_W > 16) ? POS_W : 16) + 2;

   logic [7:0]       version_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       ver_seen_ff, ver_seen_in;
   logic [7:0]       kind_seen_ff, kind_seen_in;
   logic [15:0]      seq_seen_ff, seq_seen_in;
   logic [15:0]      len_seen_ff, len_seen_in;
   logic [15:0]      chk_seen_ff, chk_seen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_kind_type     rsp_kind_ff, rsp_kind_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;

   logic             req_take;
   logic             csr_wr;
   logic [CMP_W-1:0] pos_ext, len_ext, len_new_ext, n_ext;
   logic             in_hdr, in_payload, at_chk_lo, at_chk_hi;
   logic [15:0]      crc_step;
   err_code_type     err;

   // CSR
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_VERSION) begin
         version_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_VERSION) begin
         csr_prdata[7:0] = version_ff;
      end
   end

   // handshake: hold off only while a result is stuck in the output register
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   assign pos_ext  = CMP_W'(pos_ff);
   assign len_ext  = CMP_W'(len_seen_ff);
   assign crc_step = crc_byte(crc_ff, req_tdata);

   always_comb begin
      in_hdr     = pos_ext < CMP_W'(HDR_BYTES);
      in_payload = !in_hdr && ((pos_ext - CMP_W'(HDR_BYTES)) < len_ext);
      at_chk_lo  = !in_hdr && !in_payload && (pos_ext == len_ext + CMP_W'(HDR_BYTES));
      at_chk_hi  = !in_hdr && !in_payload && (pos_ext == len_ext + CMP_W'(HDR_BYTES + 1));

      ver_seen_in  = ver_seen_ff;
      kind_seen_in = kind_seen_ff;
      seq_seen_in  = seq_seen_ff;
      len_seen_in  = len_seen_ff;
      chk_seen_in  = chk_seen_ff;
      case (pos_ff)
         POS_W'(0): ver_seen_in       = req_tdata;
         POS_W'(1): kind_seen_in      = req_tdata;
         POS_W'(2): seq_seen_in[7:0]  = req_tdata;
         POS_W'(3): seq_seen_in[15:8] = req_tdata;
         POS_W'(4): len_seen_in[7:0]  = req_tdata;
         POS_W'(5): len_seen_in[15:8] = req_tdata;
         default: ;
      endcase
      if (at_chk_lo) begin
         chk_seen_in[7:0] = req_tdata;
      end
      if (at_chk_hi) begin
         chk_seen_in[15:8] = req_tdata;
      end

      crc_in = (in_hdr || in_payload) ? crc_step : crc_ff;
      pos_in = (pos_ff < POS_W'(POS_SAT)) ? pos_ff + POS_W'(1) : POS_W'(POS_SAT);

      n_ext       = CMP_W'(pos_in);
      len_new_ext = CMP_W'(len_seen_in);

      if (n_ext < CMP_W'(HDR_BYTES + CRC_BYTES)) begin
         err = ERR_SHORT;
      end else if (ver_seen_in != version_ff) begin
         err = ERR_VERSION;
      end else if (len_new_ext > CMP_W'(MAX_PAYLOAD)) begin
         err = ERR_LENGTH;
      end else if (n_ext < len_new_ext + CMP_W'(HDR_BYTES + CRC_BYTES)) begin
         err = ERR_TRUNC;
      end else if (chk_seen_in != crc_in) begin
         err = ERR_CRC;
      end else begin
         err = ERR_OK;
      end

      rsp_data_in = '0;
      rsp_kind_in = KIND_PAYLOAD;
      if (req_tlast) begin
         rsp_kind_in                 = KIND_VERDICT;
         rsp_data_in.frame_ok        = (err == ERR_OK);
         rsp_data_in.error_code      = err;
         rsp_data_in.msg_kind        = kind_seen_in;
         rsp_data_in.sequence_res    = seq_seen_in;
         rsp_data_in.declared_length = len_seen_in;
         rsp_data_in.received_check  = chk_seen_in;
         rsp_data_in.computed_check  = crc_in;
      end else begin
         rsp_data_in.payload_byte = req_tdata;
      end

      // pass payload through only when the declared length is acceptable
      if (req_take) begin
         rsp_valid_in = req_tlast || (in_payload && len_ext <= CMP_W'(MAX_PAYLOAD));
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         ver_seen_ff  <= '0;
         kind_seen_ff <= '0;
         seq_seen_ff  <= '0;
         len_seen_ff  <= '0;
         chk_seen_ff  <= '0;
      end else if (req_take) begin
         if (req_tlast) begin
            pos_ff       <= '0;
            crc_ff       <= CRC_INIT;
            ver_seen_ff  <= '0;
            kind_seen_ff <= '0;
            seq_seen_ff  <= '0;
            len_seen_ff  <= '0;
            chk_seen_ff  <= '0;
         end else begin
            pos_ff       <= pos_in;
            crc_ff       <= crc_in;
            ver_seen_ff  <= ver_seen_in;
            kind_seen_ff <= kind_seen_in;
            seq_seen_ff  <= seq_seen_in;
            len_seen_ff  <= len_seen_in;
            chk_seen_ff  <= chk_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   property p_restart_after_last;
      @(posedge clock) disable iff (reset)
         req_take && req_tlast |=> pos_ff == '0 && crc_ff == CRC_INIT;
   endproperty
   a_restart_after_last: assert property (p_restart_after_last)
      else $error("frame state not cleared after last byte");

   property p_pos_bounded;
      @(posedge clock) disable iff (reset)
         pos_ff <= POS_W'(POS_SAT);
   endproperty
   a_pos_bounded: assert property (p_pos_bounded)
      else $error("byte position beyond saturation");

   property p_payload_fields_clear;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_kind_ff == KIND_PAYLOAD |-> rsp_data_ff[87:8] == '0;
   endproperty
   a_payload_fields_clear: assert property (p_payload_fields_clear)
      else $error("verdict fields set on a payload transfer");

   property p_ok_matches_code;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_kind_ff == KIND_VERDICT |->
            rsp_data_ff.frame_ok == (rsp_data_ff.error_code == ERR_OK);
   endproperty
   a_ok_matches_code: assert property (p_ok_matches_code)
      else $error("frame_ok disagrees with error code");

endmodule

`default_nettype wire

### tb/crc_frame_monitor.sv
`default_nettype none

package frame_crc_pkg;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      repeat (8) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ crcfc_pkg::CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

module crc_frame_monitor #(
   parameter int unsigned MAX_PAYLOAD = crcfc_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  wire logic                               req_tlast,  // last_byte
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] payload_byte, [8] frame_ok, [11:9] error_code, [19:12] msg_kind,
   // [35:20] sequence_res, [51:36] declared_length, [67:52] received_check,
   // [83:68] computed_check, [87:84] zero
   input  wire logic [87:0]                        rsp_tdata,
   input  wire logic                               rsp_tuser,  // result_kind
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [crcfc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [crcfc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  wire logic [crcfc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  wire logic                               csr_pready,
   output int                                      fail_count,
   output int                                      results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import crcfc_pkg::*;
   import frame_crc_pkg::*;

   localparam int unsigned POS_SAT = (MAX_PAYLOAD + 8 > 1023) ? MAX_PAYLOAD + 8 : 1023;
   localparam logic [CSR_ADDR_W-1:0] VERSION_ADDR = {CSR_IDX_VERSION, 2'b00};

   typedef struct packed {
      rsp_kind_type kind;
      rsp_data_type body;
   } parse_result_type;

   parse_result_type parse_results[$];

   logic [7:0]  version_cfg;
   int unsigned byte_pos;
   logic [15:0] crc_run;
   logic [7:0]  ver_seen;
   logic [7:0]  kind_seen;
   logic [15:0] seq_seen;
   logic [15:0] len_seen;
   logic [15:0] crc_rx;

   task automatic clear_frame();
      byte_pos = 0;
      crc_run  = CRC_INIT;
      ver_seen = '0;
      kind_seen = '0;
      seq_seen = '0;
      len_seen = '0;
      crc_rx   = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      int unsigned      p;
      int unsigned      len;
      int unsigned      n;
      bit               payload;
      parse_result_type r;
      err_code_type     err;
      p = byte_pos;
      len = len_seen;
      payload = 1'b0;
      case (p)
         0: ver_seen = b;
         1: kind_seen = b;
         2: seq_seen[7:0] = b;
         3: seq_seen[15:8] = b;
         4: len_seen[7:0] = b;
         5: len_seen[15:8] = b;
         default: ;
      endcase
      if (p < HDR_BYTES) begin
         crc_run = crc16_ccitt_step(crc_run, b);
      end else if (p - HDR_BYTES < len) begin
         crc_run = crc16_ccitt_step(crc_run, b);
         payload = 1'b1;
      end else if (p == HDR_BYTES + len) begin
         crc_rx[7:0] = b;
      end else if (p == HDR_BYTES + len + 1) begin
         crc_rx[15:8] = b;
      end
      n = (p < POS_SAT) ? p + 1 : POS_SAT;
      byte_pos = n;
      r = '0;
      if (!fin) begin
         // oversized frames pass no payload bytes through
         if (payload && len <= MAX_PAYLOAD) begin
            r.kind = KIND_PAYLOAD;
            r.body.payload_byte = b;
            parse_results.push_back(r);
         end
         return;
      end
      if (n < HDR_BYTES + CRC_BYTES)
         err = ERR_SHORT;
      else if (ver_seen != version_cfg)
         err = ERR_VERSION;
      else if (len_seen > MAX_PAYLOAD)
         err = ERR_LENGTH;
      else if (n < len_seen + HDR_BYTES + CRC_BYTES)
         err = ERR_TRUNC;
      else if (crc_rx != crc_run)
         err = ERR_CRC;
      else
         err = ERR_OK;
      r.kind = KIND_VERDICT;
      r.body.frame_ok = (err == ERR_OK);
      r.body.error_code = err;
      r.body.msg_kind = kind_seen;
      r.body.sequence_res = seq_seen;
      r.body.declared_length = len_seen;
      r.body.received_check = crc_rx;
      r.body.computed_check = crc_run;
      parse_results.push_back(r);
      clear_frame();
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      parse_result_type want;
      rsp_data_type     got;
      if (reset) begin
         parse_results.delete();
         version_cfg = VERSION_RESET;
         clear_frame();
      end else begin
         // take the result first: it cannot stem from a byte accepted at this edge
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got = rsp_data_type'(rsp_tdata);
            if (parse_results.size() == 0) begin
               $error("result transfer with nothing expected: kind %0b data 0x%0h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = parse_results.pop_front();
               check_field("result_kind", 16'(want.kind), 16'(rsp_tuser));
               check_field("payload_byte", 16'(want.body.payload_byte), 16'(got.payload_byte));
               check_field("frame_ok", 16'(want.body.frame_ok), 16'(got.frame_ok));
               check_field("error_code", 16'(want.body.error_code), 16'(got.error_code));
               check_field("msg_kind", 16'(want.body.msg_kind), 16'(got.msg_kind));
               check_field("sequence_res", want.body.sequence_res, got.sequence_res);
               check_field("declared_length", want.body.declared_length, got.declared_length);
               check_field("received_check", want.body.received_check, got.received_check);
               check_field("computed_check", want.body.computed_check, got.computed_check);
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            parse_byte(req_tdata, req_tlast);
         if (csr_psel && csr_penable && csr_pready === 1'b1 && csr_paddr == VERSION_ADDR) begin
            if (csr_pwrite) begin
               version_cfg = csr_pwdata[7:0];
            end else if (csr_prdata !== {24'h0, version_cfg}) begin
               $error("expected_version readback: expected 0x%0h, got 0x%0h",
                      version_cfg, csr_prdata);
               fail_count++;
            end
         end
      end
      results_due <= parse_results.size();
   end

endmodule

`default_nettype wire

### tb/tb_crc_frame_checker.sv
`default_nettype none

module tb_crc_frame_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import crcfc_pkg::*;
   import frame_crc_pkg::*;

   localparam int unsigned MAX_LEN = MAX_PAYLOAD_DEF;
   localparam logic [CSR_ADDR_W-1:0] VERSION_ADDR = {CSR_IDX_VERSION, 2'b00};

   typedef enum {
      FR_GOOD, FR_BAD_CRC, FR_BAD_VERSION, FR_OVERSIZE, FR_TRUNCATED, FR_SHORT, FR_NOISE
   } frame_shape_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [87:0]             rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;
   int                      fail_count;
   int                      results_due;

   logic [7:0]  frame_bytes[$];
   logic [7:0]  version_now;
   int          burst_left = 0;
   logic        hold_request = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          stall_mode = 0;
   int          mode_left = 0;

   crc_frame_checker dut (.*);

   crc_frame_monitor monitor (.*);

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("tb_crc_frame_checker NOT OK");
      $finish;
   end

   // receiver: its own stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 150);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // drop valid and hold until every expected result has been taken
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic build_frame(input frame_shape_type shape, input int unsigned len,
                              input int unsigned extra);
      logic [15:0] crc;
      logic [15:0] seq;
      logic [15:0] len16;
      int unsigned keep;
      frame_bytes.delete();
      if (shape == FR_NOISE) begin
         repeat (extra) frame_bytes.push_back(8'($urandom));
         return;
      end
      seq = 16'($urandom);
      len16 = 16'(len);
      frame_bytes.push_back(shape == FR_BAD_VERSION ?
                            version_now ^ 8'($urandom_range(1, 255)) : version_now);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(seq[7:0]);
      frame_bytes.push_back(seq[15:8]);
      frame_bytes.push_back(len16[7:0]);
      frame_bytes.push_back(len16[15:8]);
      if (shape == FR_OVERSIZE) begin
         repeat (extra) frame_bytes.push_back(8'($urandom));
         return;
      end
      repeat (len) frame_bytes.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (frame_bytes[i]) crc = crc16_ccitt_step(crc, frame_bytes[i]);
      if (shape == FR_BAD_CRC)
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      repeat (extra) frame_bytes.push_back(8'($urandom));
      keep = frame_bytes.size();
      if (shape == FR_TRUNCATED)
         keep = $urandom_range(HDR_BYTES + CRC_BYTES, len + HDR_BYTES + 1);
      else if (shape == FR_SHORT)
         keep = $urandom_range(1, HDR_BYTES + 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
   endtask

   task automatic send_random_frame();
      int unsigned     pick;
      int unsigned     len;
      int unsigned     extra;
      frame_shape_type shape;
      pick = $urandom_range(0, 99);
      shape = pick < 55 ? FR_GOOD : pick < 65 ? FR_BAD_CRC : pick < 72 ? FR_BAD_VERSION :
              pick < 78 ? FR_OVERSIZE : pick < 88 ? FR_TRUNCATED : pick < 94 ? FR_SHORT :
              FR_NOISE;
      pick = $urandom_range(0, 99);
      len = pick < 70 ? $urandom_range(0, 16) :
            pick < 96 ? $urandom_range(17, 80) : $urandom_range(81, MAX_LEN);
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      case (shape)
         FR_OVERSIZE: begin
            len = $urandom_range(MAX_LEN + 1, 65535);
            extra = $urandom_range(0, 24);
         end
         FR_TRUNCATED: if (len == 0) len = 1;
         FR_NOISE: extra = $urandom_range(1, 20);
         default: ;
      endcase
      build_frame(shape, len, extra);
      send_frame();
   endtask

   initial begin : stimulus
      logic [7:0] version_plan[0:5];
      int         phase_bytes;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      version_now = VERSION_RESET;

      // lone byte, short buffer of all ones, empty valid frame, one-byte frame with bad CRC
      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      build_frame(FR_GOOD, 0, 0);
      send_frame();
      build_frame(FR_BAD_CRC, 1, 0);
      send_frame();
      quiesce();

      version_plan = '{VERSION_RESET, 8'h00, 8'hFF, 8'($urandom), 8'h5A, VERSION_RESET};
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0)
            csr_access(1'b1, VERSION_ADDR, {24'h0, version_plan[phase]});
         version_now = version_plan[phase];
         csr_access(1'b0, VERSION_ADDR, '0);

         // stall the result side while a payload keeps coming, so the input backs up
         hold_request <= ~hold_request;
         build_frame(FR_GOOD, 20, 0);
         send_frame();

         if (phase == 1) begin
            // length at the limit still passes its payload; cut the buffer short
            build_frame(FR_GOOD, MAX_LEN, 0);
            while (frame_bytes.size() > 24) void'(frame_bytes.pop_back());
            send_frame();
            build_frame(FR_OVERSIZE, MAX_LEN + 1, 10);
            send_frame();
         end else if (phase == 2) begin
            // trailing bytes run the position counter into saturation
            build_frame(FR_GOOD, 3, 1030);
            send_frame();
         end else if (phase == 4) begin
            build_frame(FR_OVERSIZE, 65535, 10);
            send_frame();
         end

         phase_bytes = 0;
         while (phase_bytes < 25) begin
            send_random_frame();
            phase_bytes += frame_bytes.size();
         end
         quiesce();
      end

      if (fail_count == 0)
         $display("tb_crc_frame_checker OK");
      else
         $display("tb_crc_frame_checker NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/crcfc_pkg.sv
hw/rtl/crc_frame_checker.sv
tb/crc_frame_monitor.sv
tb/tb_crc_frame_checker.sv
